[sv/pdfp_pkg.sv]
package pdfp_pkg;

  localparam int CALL_CHARS = 8;
  localparam int GRID_CHARS = 8;
  localparam int CHAR_IDX_W = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_VERSION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_SIZE   = 1'b1;

  localparam logic [6:0]  PROTOCOL_VERSION_RST = 7'd1;
  localparam logic [15:0] MAX_FRAME_SIZE_RST   = 16'd8192;

  localparam logic [7:0] CH_PIPE = 8'h7C;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_Q    = 8'h51;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_N    = 8'h4E;

  typedef enum logic [2:0] {
    FK_M = 3'd0,
    FK_Q = 3'd1,
    FK_R = 3'd2,
    FK_B = 3'd3,
    FK_A = 3'd4,
    FK_N = 3'd5
  } frame_kind_e;

  typedef enum logic [1:0] {
    RK_PAYLOAD = 2'd0,
    RK_DONE    = 2'd1,
    RK_ERROR   = 2'd2
  } result_kind_e;

  typedef enum logic [2:0] {
    EC_NONE        = 3'd0,
    EC_MISSING_PIPE = 3'd1,
    EC_BAD_TYPE    = 3'd2,
    EC_BAD_VERSION = 3'd3,
    EC_BAD_HEX     = 3'd4,
    EC_TOO_LONG    = 3'd5,
    EC_SIZE_SHORT  = 3'd6
  } error_cause_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_TYPE,
    PH_VER,
    PH_PIPE2,
    PH_FROM,
    PH_TO,
    PH_SIZE,
    PH_SPIPE,
    PH_GRID,
    PH_CHECK,
    PH_CPIPE,
    PH_PAYLOAD
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       chunk_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [2:0]  frame_kind;
    logic [63:0] sender_call;
    logic [63:0] receiver_call;
    logic [63:0] grid_square;
    logic [15:0] check_value;
    logic [15:0] frame_size;
    logic [15:0] header_length;
    logic [2:0]  error_cause;
  } out_item_t;

  // classified byte as it sits in the queue
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        chunk_start;
    logic        is_pipe;
    logic        is_digit;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic        type_ok;
    frame_kind_e type_kind;
  } token_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

[sv/pdfp_front.sv]
module pdfp_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pdfp_pkg::in_item_t      in_data_i,
  output logic                    tok_valid_o,
  input  logic                    tok_pop_i,
  output pdfp_pkg::token_t        tok_o,
  output pdfp_pkg::queue_status_t status_o
);
  import pdfp_pkg::*;

  token_t                 tok;
  token_t                 queue_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] count_q, count_d;
  logic                   push, pop;
  logic [7:0]             b;

  assign b = in_data_i.rx_byte;

  always_comb begin
    tok             = '0;
    tok.rx_byte     = b;
    tok.chunk_start = in_data_i.chunk_start;
    tok.is_pipe     = (b == CH_PIPE);
    tok.is_digit    = (b >= 8'h30) && (b <= 8'h39);
    if (tok.is_digit) begin
      tok.hex_ok  = 1'b1;
      tok.hex_val = b[3:0];
    end else if (((b >= 8'h41) && (b <= 8'h46)) || ((b >= 8'h61) && (b <= 8'h66))) begin
      tok.hex_ok  = 1'b1;
      tok.hex_val = b[3:0] + 4'd9;
    end
    tok.type_ok = 1'b1;
    unique case (b)
      CH_M:    tok.type_kind = FK_M;
      CH_Q:    tok.type_kind = FK_Q;
      CH_R:    tok.type_kind = FK_R;
      CH_B:    tok.type_kind = FK_B;
      CH_A:    tok.type_kind = FK_A;
      CH_N:    tok.type_kind = FK_N;
      default: begin
        tok.type_ok   = 1'b0;
        tok.type_kind = FK_M;
      end
    endcase
  end

  assign in_ready_o  = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign tok_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = tok_pop_i && tok_valid_o;
  assign tok_o       = queue_q[rd_ptr_q];

  assign status_o.empty = !tok_valid_o;
  assign status_o.full  = !in_ready_o;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= tok;
    end
  end

endmodule

[sv/pdfp_back.sv]
module pdfp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pdfp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pdfp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              tok_valid_i,
  output logic                              tok_pop_o,
  input  pdfp_pkg::token_t                  tok_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pdfp_pkg::out_item_t               out_data_o
);
  import pdfp_pkg::*;

  logic [6:0]  ver_q;
  logic [15:0] max_q;

  phase_e      ph_q, ph_d;
  frame_kind_e kind_q, kind_d;
  logic [63:0] sender_q, sender_d;
  logic [63:0] receiver_q, receiver_d;
  logic [63:0] grid_q, grid_d;
  logic [3:0]  fcc_q, fcc_d;
  logic [15:0] acc_q, acc_d;
  logic [2:0]  dcnt_q, dcnt_d;
  logic [15:0] size_q, size_d;
  logic [15:0] check_q, check_d;
  logic [15:0] hcnt_q, hcnt_d;
  logic [15:0] left_q, left_d;

  logic         out_valid_q, out_valid_d;
  out_item_t    out_q, out_d;

  logic         step;
  logic         res_valid;
  result_kind_e res_kind;
  error_cause_e res_cause;
  logic         res_pbyte;
  logic [7:0]   b;
  logic [CHAR_IDX_W-1:0] cidx;

  assign b         = tok_i.rx_byte;
  assign cidx      = fcc_q[CHAR_IDX_W-1:0];
  assign tok_pop_o = tok_valid_i && (!out_valid_q || out_ready_i);
  assign step      = tok_pop_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_q <= PROTOCOL_VERSION_RST;
      max_q <= MAX_FRAME_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROTOCOL_VERSION: ver_q <= cfg_data_i[6:0];
        CFG_MAX_FRAME_SIZE:   max_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ph_d       = ph_q;
    kind_d     = kind_q;
    sender_d   = sender_q;
    receiver_d = receiver_q;
    grid_d     = grid_q;
    fcc_d      = fcc_q;
    acc_d      = acc_q;
    dcnt_d     = dcnt_q;
    size_d     = size_q;
    check_d    = check_q;
    hcnt_d     = hcnt_q;
    left_d     = left_q;
    res_valid  = 1'b0;
    res_kind   = RK_PAYLOAD;
    res_cause  = EC_NONE;
    res_pbyte  = 1'b0;

    if (step) begin
      if (tok_i.chunk_start) begin
        kind_d     = FK_M;
        sender_d   = '0;
        receiver_d = '0;
        grid_d     = '0;
        fcc_d      = '0;
        acc_d      = '0;
        dcnt_d     = '0;
        size_d     = '0;
        check_d    = '0;
        left_d     = '0;
        if (!tok_i.is_pipe) begin
          hcnt_d    = '0;
          ph_d      = PH_IDLE;
          res_valid = 1'b1;
          res_kind  = RK_ERROR;
          res_cause = EC_MISSING_PIPE;
        end else begin
          hcnt_d = 16'd1;
          ph_d   = PH_TYPE;
        end
      end else begin
        unique case (ph_q)
          PH_TYPE: begin
            if (!tok_i.type_ok) begin
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_cause = EC_BAD_TYPE;
            end else begin
              kind_d = tok_i.type_kind;
              hcnt_d = hcnt_q + 16'd1;
              acc_d  = '0;
              dcnt_d = '0;
              ph_d   = PH_VER;
            end
          end
          PH_VER: begin
            if (!tok_i.is_digit) begin
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_cause = EC_BAD_VERSION;
            end else begin
              acc_d  = (acc_q << 3) + (acc_q << 1) + {12'd0, b[3:0]};
              dcnt_d = dcnt_q + 3'd1;
              hcnt_d = hcnt_q + 16'd1;
              if (dcnt_d >= 3'd2) begin
                if (acc_d != {9'd0, ver_q}) begin
                  res_valid = 1'b1;
                  res_kind  = RK_ERROR;
                  res_cause = EC_BAD_VERSION;
                end else begin
                  ph_d = PH_PIPE2;
                end
              end
            end
          end
          PH_PIPE2: begin
            if (!tok_i.is_pipe) begin
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_cause = EC_MISSING_PIPE;
            end else begin
              hcnt_d = hcnt_q + 16'd1;
              fcc_d  = '0;
              ph_d   = PH_FROM;
            end
          end
          PH_FROM: begin
            hcnt_d = hcnt_q + 16'd1;
            if (tok_i.is_pipe) begin
              fcc_d  = '0;
              acc_d  = '0;
              dcnt_d = '0;
              ph_d   = (kind_q == FK_B) ? PH_SIZE : PH_TO;
            end else if (fcc_q >= 4'(CALL_CHARS)) begin
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_cause = EC_TOO_LONG;
            end else begin
              sender_d[{cidx, 3'b000} +: 8] = b;
              fcc_d = fcc_q + 4'd1;
            end
          end
          PH_TO: begin
            hcnt_d = hcnt_q + 16'd1;
            if (tok_i.is_pipe) begin
              if ((kind_q == FK_A) || (kind_q == FK_N)) begin
                size_d    = hcnt_d;
                res_valid = 1'b1;
                res_kind  = RK_DONE;
              end else begin
                acc_d  = '0;
                dcnt_d = '0;
                ph_d   = PH_SIZE;
              end
            end else if (fcc_q >= 4'(CALL_CHARS)) begin
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_cause = EC_TOO_LONG;
            end else begin
              receiver_d[{cidx, 3'b000} +: 8] = b;
              fcc_d = fcc_q + 4'd1;
            end
          end
          PH_SIZE, PH_CHECK: begin
            if (!tok_i.hex_ok) begin
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_cause = EC_BAD_HEX;
            end else begin
              acc_d  = {acc_q[11:0], tok_i.hex_val};
              dcnt_d = dcnt_q + 3'd1;
              hcnt_d = hcnt_q + 16'd1;
              if (dcnt_d >= 3'd4) begin
                if (ph_q == PH_CHECK) begin
                  check_d = acc_d;
                  ph_d    = PH_CPIPE;
                end else if (acc_d >= max_q) begin
                  size_d    = acc_d;
                  res_valid = 1'b1;
                  res_kind  = RK_ERROR;
                  res_cause = EC_BAD_HEX;
                end else begin
                  size_d = acc_d;
                  ph_d   = PH_SPIPE;
                end
              end
            end
          end
          PH_SPIPE: begin
            if (!tok_i.is_pipe) begin
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_cause = EC_MISSING_PIPE;
            end else begin
              hcnt_d = hcnt_q + 16'd1;
              fcc_d  = '0;
              acc_d  = '0;
              dcnt_d = '0;
              ph_d   = (kind_q == FK_B) ? PH_GRID : PH_CHECK;
            end
          end
          PH_GRID, PH_CPIPE: begin
            hcnt_d = hcnt_q + 16'd1;
            if ((ph_q == PH_CPIPE) && !tok_i.is_pipe) begin
              hcnt_d    = hcnt_q;
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_cause = EC_MISSING_PIPE;
            end else if (tok_i.is_pipe) begin
              // header complete: check size against header length
              if (size_q < hcnt_d) begin
                res_valid = 1'b1;
                res_kind  = RK_ERROR;
                res_cause = EC_SIZE_SHORT;
              end else if (size_q == hcnt_d) begin
                res_valid = 1'b1;
                res_kind  = RK_DONE;
              end else begin
                left_d = size_q - hcnt_d;
                ph_d   = PH_PAYLOAD;
              end
            end else if (fcc_q >= 4'(GRID_CHARS)) begin
              res_valid = 1'b1;
              res_kind  = RK_ERROR;
              res_cause = EC_TOO_LONG;
            end else begin
              grid_d[{cidx, 3'b000} +: 8] = b;
              fcc_d = fcc_q + 4'd1;
            end
          end
          PH_PAYLOAD: begin
            left_d    = left_q - 16'd1;
            res_valid = 1'b1;
            res_pbyte = 1'b1;
            res_kind  = (left_d == '0) ? RK_DONE : RK_PAYLOAD;
          end
          default: ph_d = PH_IDLE;
        endcase
        if (res_valid && (res_kind != RK_PAYLOAD)) begin
          ph_d = PH_IDLE;
        end
      end
    end
  end

  always_comb begin
    out_d               = '0;
    out_d.result_kind   = res_kind;
    out_d.error_cause   = res_cause;
    out_d.payload_valid = res_pbyte;
    out_d.payload_byte  = res_pbyte ? b : 8'd0;
    if (res_kind == RK_DONE) begin
      out_d.frame_kind    = kind_d;
      out_d.sender_call   = sender_d;
      out_d.receiver_call = receiver_d;
      out_d.grid_square   = grid_d;
      out_d.check_value   = check_d;
      out_d.frame_size    = size_d;
      out_d.header_length = hcnt_d;
    end
    if (step && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_IDLE;
      kind_q      <= FK_M;
      sender_q    <= '0;
      receiver_q  <= '0;
      grid_q      <= '0;
      fcc_q       <= '0;
      acc_q       <= '0;
      dcnt_q      <= '0;
      size_q      <= '0;
      check_q     <= '0;
      hcnt_q      <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ph_q        <= ph_d;
      kind_q      <= kind_d;
      sender_q    <= sender_d;
      receiver_q  <= receiver_d;
      grid_q      <= grid_d;
      fcc_q       <= fcc_d;
      acc_q       <= acc_d;
      dcnt_q      <= dcnt_d;
      size_q      <= size_d;
      check_q     <= check_d;
      hcnt_q      <= hcnt_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[sv/pipe_delimited_frame_parser.sv]
// Pipe-delimited frame header parser.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one received byte
// per transfer plus a chunk_start flag; a byte with chunk_start set always
// restarts the parse and must be a pipe. Output channel (out_valid_o /
// out_ready_i / out_data_o) delivers payload bytes, a frame-done record with
// the parsed header, or an error with a cause. Header bytes that neither end
// the frame nor raise an error, and ignored bytes, give no transfer on the output.
// Throughput: one byte per cycle, sustained, while the receiver keeps up.
// A byte accepted on the input is written into the two-entry classification
// queue; once the parser can step, it is carried through the parser into the
// output register.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
// next edge; write only while no byte is in flight.
// Reset puts the parser idle, waiting for a chunk start, and loads version 1
// and maximum frame size 8192. When the receiver stalls the output register
// holds its result, the parser stops, and the queue fills; in_ready_o drops
// once both queue entries are taken.
module pipe_delimited_frame_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pdfp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pdfp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pdfp_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pdfp_pkg::out_item_t             out_data_o
);
  import pdfp_pkg::*;

  logic          tok_valid;
  logic          tok_pop;
  token_t        tok;
  queue_status_t q_status;

  pdfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .tok_valid_o (tok_valid),
    .tok_pop_i   (tok_pop),
    .tok_o       (tok),
    .status_o    (q_status)
  );

  pdfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .tok_valid_i (tok_valid),
    .tok_pop_o   (tok_pop),
    .tok_i       (tok),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_push_fills_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !q_status.empty)
    else $error("queue empty after a transfer in");

  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_pop |-> !q_status.empty && (!out_valid_o || out_ready_i))
    else $error("parser stepped without a token or without output room");

  a_payload_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.payload_valid |-> out_data_o.result_kind != RK_ERROR)
    else $error("payload byte on an error result");

  a_error_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.result_kind == RK_ERROR) |-> out_data_o.error_cause != EC_NONE)
    else $error("error result without a cause");

endmodule
